// ===== src/assert_macros.svh =====
// Assertion macros shared by the scanner RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define STS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sts_pkg.sv =====
// Types and constants for the S-expression token scanner.
// No dependencies; used by every scanner module.
package sts_pkg;

  // Scanner mode; the fourth code is unused and treated as idle
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } scan_mode_t;

  // Token classes
  localparam logic [2:0] CLS_SPACE  = 3'd0;
  localparam logic [2:0] CLS_LPAREN = 3'd1;
  localparam logic [2:0] CLS_RPAREN = 3'd2;
  localparam logic [2:0] CLS_IDENT  = 3'd3;
  localparam logic [2:0] CLS_NUMBER = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BADCHAR  = 2'd1;
  localparam logic [1:0] ERR_LEADZERO = 2'd2;

  // Characters with special meaning
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_TILDE      = 8'h7E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;

  // Per-byte character flags
  typedef struct packed {
    logic ident_start;
    logic ident_more;
    logic digit;
    logic zero;
    logic space;
    logic lparen;
    logic rparen;
  } chr_flags_t;

  // Per-byte result fields
  typedef struct packed {
    logic [1:0] err;
    logic       start;
    logic [2:0] cls;
  } sts_result_t;

endpackage

// ===== src/sts_char_class.sv =====
// Character classifier for the token scanner: decodes one byte into flags.
// Depends on sts_pkg.
module sts_char_class
  import sts_pkg::*;
(
  input  logic [7:0]  char_byte,
  output chr_flags_t  flags
);

  logic ident_start;

  always_comb begin
    ident_start = 1'b0;
    if (char_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
      ident_start = 1'b1;
    end
    // ! $ % & * / : < = > ? ^ _ ~ + -
    if (char_byte inside {8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2F, 8'h3A, 8'h3C,
                          8'h3D, 8'h3E, 8'h3F, 8'h5E, CH_UNDERSCORE, CH_TILDE,
                          8'h2B, 8'h2D}) begin
      ident_start = 1'b1;
    end
  end

  always_comb begin
    flags             = '0;
    flags.ident_start = ident_start;
    flags.ident_more  = ident_start || (char_byte == CH_DOT) || (char_byte == CH_AT);
    flags.digit       = (char_byte inside {[CH_ZERO:CH_NINE]});
    flags.zero        = (char_byte == CH_ZERO);
    flags.space       = (char_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR});
    flags.lparen      = (char_byte == CH_LPAREN);
    flags.rparen      = (char_byte == CH_RPAREN);
  end

endmodule

// ===== src/sts_scan_core.sv =====
// Scanner state machine: holds mode, lone-zero and sticky error state and
// tags each byte from its character flags. Depends on sts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sts_scan_core
  import sts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  chr_flags_t  flags,
  input  logic        last,
  output sts_result_t res
);

  scan_mode_t mode_r, mode_nxt;
  logic       lone_zero_r, lone_zero_nxt;
  logic       failed_r, failed_nxt;

  logic cont_ident;
  logic cont_number;

  assign cont_ident  = (mode_r == MODE_IDENT) && flags.ident_more;
  assign cont_number = (mode_r == MODE_NUMBER) && flags.digit;

  // Result for the current byte
  always_comb begin
    res       = '0;
    res.cls   = CLS_SPACE;
    res.start = 1'b0;
    res.err   = ERR_NONE;
    if (failed_r) begin
      res.err = lone_zero_r ? ERR_LEADZERO : ERR_BADCHAR;
    end else if (cont_ident) begin
      res.cls = CLS_IDENT;
    end else if (cont_number) begin
      if (lone_zero_r) begin
        res.err = ERR_LEADZERO;
      end else begin
        res.cls = CLS_NUMBER;
      end
    end else if (flags.space) begin
      res.cls = CLS_SPACE;
    end else if (flags.lparen) begin
      res.cls   = CLS_LPAREN;
      res.start = 1'b1;
    end else if (flags.rparen) begin
      res.cls   = CLS_RPAREN;
      res.start = 1'b1;
    end else if (flags.ident_start) begin
      res.cls   = CLS_IDENT;
      res.start = 1'b1;
    end else if (flags.digit) begin
      res.cls   = CLS_NUMBER;
      res.start = 1'b1;
    end else begin
      res.err = ERR_BADCHAR;
    end
  end

  // Next state
  always_comb begin
    mode_nxt      = mode_r;
    lone_zero_nxt = lone_zero_r;
    failed_nxt    = failed_r;
    if (failed_r) begin
      mode_nxt = MODE_IDLE;
    end else if (cont_ident) begin
      mode_nxt = MODE_IDENT;
    end else if (cont_number) begin
      if (lone_zero_r) begin
        failed_nxt    = 1'b1;
        mode_nxt      = MODE_IDLE;
        lone_zero_nxt = 1'b1;
      end
    end else begin
      mode_nxt      = MODE_IDLE;
      lone_zero_nxt = 1'b0;
      if (flags.space || flags.lparen || flags.rparen) begin
        mode_nxt = MODE_IDLE;
      end else if (flags.ident_start) begin
        mode_nxt = MODE_IDENT;
      end else if (flags.digit) begin
        mode_nxt      = MODE_NUMBER;
        lone_zero_nxt = flags.zero;
      end else begin
        failed_nxt = 1'b1;
      end
    end
    // End of source: back to reset state
    if (last) begin
      mode_nxt      = MODE_IDLE;
      lone_zero_nxt = 1'b0;
      failed_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      lone_zero_r <= 1'b0;
      failed_r    <= 1'b0;
    end else if (advance) begin
      mode_r      <= mode_nxt;
      lone_zero_r <= lone_zero_nxt;
      failed_r    <= failed_nxt;
    end
  end

  `STS_ASSERT_NOW(a_failed_idle, failed_r, mode_r == MODE_IDLE, "failed while inside a token")
  `STS_ASSERT_NEXT(a_last_resets, advance && last, (mode_r == MODE_IDLE) && !failed_r && !lone_zero_r, "state not cleared after last word")
  `STS_ASSERT_NOW(a_sticky_error, advance && failed_r, (res.cls == CLS_SPACE) && !res.start && (res.err != ERR_NONE), "failed scanner emitted a token")
  `STS_ASSERT_NOW(a_leadzero_src, advance && !failed_r && (res.err == ERR_LEADZERO), (mode_r == MODE_NUMBER) && lone_zero_r, "leading-zero error outside a lone zero")

endmodule

// ===== src/sts_token_scanner_top_note.sv =====
// Output register stage of the token scanner: holds one tagged word until taken.
// Depends on sts_pkg.
module sts_out_stage
  import sts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  sts_result_t res,
  input  logic        last,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  output logic        free
);

  logic        vld_r, vld_nxt;
  sts_result_t res_r;
  logic        last_r;

  assign free    = !vld_r || out_tready;
  assign vld_nxt = load || (vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload loads only when a new word moves in
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= res;
      last_r <= last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {2'b00, res_r.err, res_r.start, res_r.cls};
  assign out_tlast  = last_r;

endmodule

// ===== src/sexpr_token_scanner.sv =====
// S-expression token scanner: tags each source byte with its token class,
// a start-of-token flag and a sticky error code. Input register, classifier
// and state machine feeding a result register. One byte per clock cycle
// sustained while out_tready is high; each byte waits in the input register,
// then its word moves to the result register and stays until it is taken.
// The scan state machine updates once per byte.
// Depends on sts_pkg, sts_char_class, sts_scan_core and sts_out_stage.
module sexpr_token_scanner
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic       in_tlast,   // stream_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] token_class, [3] starts_token,
                                 // [5:4] error_code, [7:6] zero
  output logic       out_tlast   // final_byte
);

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic        in_take;
  logic        advance;
  logic        out_free;
  chr_flags_t  flags;
  sts_result_t res;

  assign advance    = in_vld_r && out_free;
  assign in_tready  = !in_vld_r || advance;
  assign in_take    = in_tvalid && in_tready;
  assign in_vld_nxt = in_take || (in_vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // Hold the byte until the scan stage takes it
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  sts_char_class u_class (
    .char_byte (in_byte_r),
    .flags     (flags)
  );

  sts_scan_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .flags   (flags),
    .last    (in_last_r),
    .res     (res)
  );

  sts_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .last       (in_last_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .free       (out_free)
  );

endmodule

// ===== dv/tb.sv =====
// Testbench for sexpr_token_scanner: a table of directed bytes, then random
// streams of tokens, checked word by word against the table's expectations or a byte-tagging predictor.
// Depends on sts_pkg and the scanner RTL in src.
module tb;
  import sts_pkg::*;

  typedef struct packed {
    logic [2:0] cls;
    logic       start;
    logic [1:0] err;
    logic       fin;
  } scan_tag_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    scan_tag_t  want;
  } byte_item_t;

  // Directed rows: byte, stream end, typed flag, then expected class/start/error
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    logic [2:0] cls;
    logic       start;
    logic [1:0] err;
  } dir_row_t;

  localparam int N_DIR = 25;
  localparam int N_RAND = 1350;
  localparam int HOLD_CYCLES = 200;

  dir_row_t dir_rows [N_DIR] = '{
    '{CH_SPACE,  1'b0, 1'b1, CLS_SPACE,  1'b0, ERR_NONE},
    '{CH_LPAREN, 1'b0, 1'b1, CLS_LPAREN, 1'b1, ERR_NONE},
    '{8'h61,     1'b0, 1'b1, CLS_IDENT,  1'b1, ERR_NONE},     // a
    '{CH_DOT,    1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
    '{CH_AT,     1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
    '{8'h37,     1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},     // 7 ends identifier
    '{CH_ZERO,   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
    '{8'h7A,     1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},     // z ends number
    '{CH_RPAREN, 1'b0, 1'b1, CLS_RPAREN, 1'b1, ERR_NONE},
    '{CH_ZERO,   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
    '{8'h35,     1'b0, 1'b1, CLS_SPACE,  1'b0, ERR_LEADZERO}, // digit after lone zero
    '{8'h78,     1'b0, 1'b1, CLS_SPACE,  1'b0, ERR_LEADZERO},
    '{8'hFF,     1'b1, 1'b1, CLS_SPACE,  1'b0, ERR_LEADZERO},
    '{CH_DOT,    1'b0, 1'b1, CLS_SPACE,  1'b0, ERR_BADCHAR},  // dot outside identifier
    '{CH_LPAREN, 1'b1, 1'b1, CLS_SPACE,  1'b0, ERR_BADCHAR},
    '{8'h00,     1'b1, 1'b1, CLS_SPACE,  1'b0, ERR_BADCHAR},
    '{CH_AT,     1'b1, 1'b1, CLS_SPACE,  1'b0, ERR_BADCHAR},
    '{CH_TAB,    1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
    '{CH_TILDE,  1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
    '{CH_UNDERSCORE, 1'b0, 1'b0, CLS_SPACE, 1'b0, ERR_NONE},
    '{CH_NINE,   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
    '{CH_CR,     1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
    '{CH_LF,     1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
    '{CH_ZERO,   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
    '{CH_RPAREN, 1'b1, 1'b0, CLS_SPACE,  1'b0, ERR_NONE}
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  sexpr_token_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  byte_item_t stim[$];
  scan_tag_t  tag_queue[$];
  scan_tag_t  head_tag;
  int         fails = 0;
  int         phase = 0;
  int         hold_left = 0;
  bit         held = 1'b0;

  // Predictor state
  scan_mode_t lex_mode = MODE_IDLE;
  logic       lone_zero = 1'b0;
  logic       err_latched = 1'b0;

  function automatic logic is_head(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           c == 8'h21 || c == 8'h24 || c == 8'h25 || c == 8'h26 || c == 8'h2A ||
           c == 8'h2F || c == 8'h3A || c == 8'h3C || c == 8'h3D || c == 8'h3E ||
           c == 8'h3F || c == 8'h5E || c == CH_UNDERSCORE || c == CH_TILDE ||
           c == 8'h2B || c == 8'h2D;
  endfunction

  function automatic logic is_tail(logic [7:0] c);
    return is_head(c) || c == CH_DOT || c == CH_AT;
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function scan_tag_t tag_byte(logic [7:0] c, logic fin);
    scan_tag_t r;
    r = '0;
    r.cls = CLS_SPACE;
    r.err = ERR_NONE;
    r.fin = fin;
    if (err_latched) begin
      r.err = lone_zero ? ERR_LEADZERO : ERR_BADCHAR;
    end else if (lex_mode == MODE_IDENT && is_tail(c)) begin
      r.cls = CLS_IDENT;
    end else if (lex_mode == MODE_NUMBER && is_num(c)) begin
      if (lone_zero) begin
        r.err = ERR_LEADZERO;
        err_latched = 1'b1;
        lex_mode = MODE_IDLE;
      end else begin
        r.cls = CLS_NUMBER;
      end
    end else begin
      // current token, if any, ends here; classify from idle
      lex_mode = MODE_IDLE;
      lone_zero = 1'b0;
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
        r.cls = CLS_SPACE;
      end else if (c == CH_LPAREN) begin
        r.cls = CLS_LPAREN;
        r.start = 1'b1;
      end else if (c == CH_RPAREN) begin
        r.cls = CLS_RPAREN;
        r.start = 1'b1;
      end else if (is_head(c)) begin
        r.cls = CLS_IDENT;
        r.start = 1'b1;
        lex_mode = MODE_IDENT;
      end else if (is_num(c)) begin
        r.cls = CLS_NUMBER;
        r.start = 1'b1;
        lex_mode = MODE_NUMBER;
        lone_zero = (c == CH_ZERO);
      end else begin
        r.err = ERR_BADCHAR;
        err_latched = 1'b1;
      end
    end
    if (fin) begin
      lex_mode = MODE_IDLE;
      lone_zero = 1'b0;
      err_latched = 1'b0;
    end
    return r;
  endfunction

  function void push_byte(logic [7:0] c);
    byte_item_t it;
    it = '0;
    it.ch = c;
    stim.push_back(it);
  endfunction

  function automatic logic [7:0] pick_head();
    string syms = "!$%&*/:<=>?^_~+-";
    int r;
    r = $urandom_range(0, 67);
    if (r < 26) return 8'h41 + 8'(r);
    if (r < 52) return 8'h61 + 8'(r - 26);
    return syms[r - 52];
  endfunction

  function automatic logic [7:0] pick_tail();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? CH_DOT : CH_AT;
    return pick_head();
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stalls in the first two phases, plus one long hold-off in the last phase
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && phase == 2) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(0, 99) >= (phase == 0 ? 79 : phase == 1 ? 35 : 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (tag_queue.size() == 0) begin
        $error("unexpected word: tdata %h tlast %b", out_tdata, out_tlast);
        fails++;
      end else begin
        head_tag = tag_queue.pop_front();
        if (out_tdata[2:0] !== head_tag.cls) begin
          $error("token_class: expected %0d, got %0d", head_tag.cls, out_tdata[2:0]);
          fails++;
        end
        if (out_tdata[3] !== head_tag.start) begin
          $error("starts_token: expected %0d, got %0d", head_tag.start, out_tdata[3]);
          fails++;
        end
        if (out_tdata[5:4] !== head_tag.err) begin
          $error("error_code: expected %0d, got %0d", head_tag.err, out_tdata[5:4]);
          fails++;
        end
        if (out_tdata[7:6] !== 2'b00) begin
          $error("tdata pad: expected 0, got %0d", out_tdata[7:6]);
          fails++;
        end
        if (out_tlast !== head_tag.fin) begin
          $error("final_byte: expected %0d, got %0d", head_tag.fin, out_tlast);
          fails++;
        end
      end
    end
  end

  initial begin
    byte_item_t it;
    scan_tag_t  guess;
    int         span;
    int         first;
    int         kind;
    int         tx_pct;

    for (int i = 0; i < N_DIR; i++) begin
      it.ch = dir_rows[i].ch;
      it.fin = dir_rows[i].fin;
      it.typed = dir_rows[i].typed;
      it.want = {dir_rows[i].cls, dir_rows[i].start, dir_rows[i].err, dir_rows[i].fin};
      stim.push_back(it);
    end

    // Random streams: mostly well-formed tokens, some noise and broken bytes
    while (stim.size() < N_DIR + N_RAND) begin
      span = $urandom_range(1, 40);
      first = stim.size();
      while (stim.size() - first < span) begin
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
          push_byte(8'($urandom_range(0, 255)));
        end else if (kind < 22) begin
          case ($urandom_range(0, 3))
            0: push_byte(CH_SPACE);
            1: push_byte(CH_TAB);
            2: push_byte(CH_LF);
            default: push_byte(CH_CR);
          endcase
        end else if (kind < 40) begin
          push_byte($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
        end else if (kind < 68) begin
          push_byte(pick_head());
          repeat ($urandom_range(0, 6)) push_byte(pick_tail());
        end else if (kind < 97) begin
          if ($urandom_range(0, 3) == 0) begin
            push_byte(CH_ZERO);
            if ($urandom_range(0, 2) == 0) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
          end else begin
            push_byte(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(0, 5)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
          end
        end else begin
          push_byte($urandom_range(0, 1) ? CH_DOT : CH_AT);
        end
      end
      it = stim.pop_back();
      it.fin = 1'b1;
      stim.push_back(it);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < stim.size(); i++) begin
      phase = (i < stim.size() / 3) ? 0 : (i < 2 * stim.size() / 3) ? 1 : 2;
      tx_pct = (phase == 0) ? 35 : (phase == 1) ? 79 : 0;
      it = stim[i];
      @(negedge clk);
      while ($urandom_range(0, 99) < tx_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= it.ch;
      in_tlast <= it.fin;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      // advance the predictor even where the row gives its own expectation
      guess = tag_byte(it.ch, it.fin);
      tag_queue.push_back(it.typed ? it.want : guess);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (tag_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
